// ----- rtl/wdb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdb_pkg
// Shared types, constants and tables of the waypoint distance and bearing
// pipeline.
// ----------------------------------------------------------------------------
package wdb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  typedef logic signed [31:0] dlat_t;
  typedef logic signed [32:0] dlon_t;
  typedef logic signed [23:0] deg_t;
  typedef logic signed [33:0] cval_t;
  typedef logic signed [63:0] vval_t;
  typedef logic signed [35:0] vang_t;
  typedef logic signed [27:0] mlon_t;
  typedef logic signed [16:0] bear_t;
  typedef logic signed [27:0] tdeg_t;

  typedef struct packed {
    dlat_t dlat;
    dlon_t dlon;
  } diff_t;

  typedef struct packed {
    deg_t r;
    logic neg;
  } red_t;

  localparam cval_t GAIN_Q30 = 34'sd652032874;
  localparam logic [29:0] GAIN_U = 30'd652032874;
  localparam vang_t PI_Q30 = 36'sd3373259426;
  localparam vang_t HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [25:0] DEG2RAD_Q30 = 26'sd18740330;
  localparam logic signed [26:0] MLAT_Q8 = 27'sd28450022;
  localparam logic signed [26:0] C1_COEF = 27'sd28521697;
  localparam logic signed [26:0] C3_COEF = 27'sd23936;
  localparam logic signed [26:0] C5_COEF = 27'sd31;
  localparam tdeg_t FULL_DEG = 28'sd23592960;
  localparam tdeg_t HALF_DEG = 28'sd11796480;
  localparam tdeg_t QUARTER_DEG = 28'sd5898240;
  localparam logic [26:0] DIST_DIV = 27'd100000000;
  localparam logic [28:0] DIST_DIV2 = 29'd200000000;
  localparam logic [28:0] DIST_DIV3 = 29'd300000000;
  // floor(2^59 / 1e8), applied to the magnitude shifted right by 27.
  localparam logic [32:0] DIST_RECIP = 33'd5764607523;
  localparam logic [63:0] DIST_LIM = 64'd429496729600000000;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;
      1: v = 32'h1DAC6705;
      2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;
      4: v = 32'h03FEAB76;
      5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;
      7: v = 32'h007FFF55;
      8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Brings an angle in Q.16 degrees into [-90, 90] and notes whether the
  // cosine changes sign on the way.
  function automatic red_t reduce_deg(input tdeg_t t);
    tdeg_t r;
    red_t o;
    r = t;
    if (r < 0) r = r + FULL_DEG;
    if (r < 0) r = r + FULL_DEG;
    if (r >= FULL_DEG) r = r - FULL_DEG;
    if (r >= HALF_DEG) r = r - FULL_DEG;
    o.neg = 1'b0;
    if (r > QUARTER_DEG) begin
      r = r - HALF_DEG;
      o.neg = 1'b1;
    end else if (r < -QUARTER_DEG) begin
      r = r + HALF_DEG;
      o.neg = 1'b1;
    end
    o.r = r[23:0];
    return o;
  endfunction

endpackage

// ----- rtl/wdb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdb_in_if / wdb_out_if
// Valid/ready channels for query and result transactions.
// ----------------------------------------------------------------------------
interface wdb_in_if;
  logic valid;
  logic ready;
  logic signed [30:0] pos_lat_fixed;
  logic signed [31:0] pos_lon_fixed;
  logic signed [30:0] wp_lat_fixed;
  logic signed [31:0] wp_lon_fixed;
  logic signed [23:0] pos_lat_deg;

  modport source (output valid, pos_lat_fixed, pos_lon_fixed, wp_lat_fixed, wp_lon_fixed,
                  pos_lat_deg, input ready);
  modport sink (input valid, pos_lat_fixed, pos_lon_fixed, wp_lat_fixed, wp_lon_fixed,
                pos_lat_deg, output ready);
endinterface

interface wdb_out_if;
  logic valid;
  logic ready;
  logic [31:0] distance_q8;
  logic signed [16:0] bearing_q13;

  modport source (output valid, distance_q8, bearing_q13, input ready);
  modport sink (input valid, distance_q8, bearing_q13, output ready);
endinterface

// ----- rtl/wdb_cos_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdb_cos_unit
// Longitude metres per degree from a three-term cosine series, with three
// unrolled rotation CORDIC lanes for cos L, cos 3L and cos 5L.
// ----------------------------------------------------------------------------
module wdb_cos_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  wdb_pkg::deg_t   lat_deg,
  input  wdb_pkg::diff_t  in_diff,
  output logic            out_valid,
  output wdb_pkg::mlon_t  mlon,
  output wdb_pkg::diff_t  out_diff
);
  import wdb_pkg::*;

  tdeg_t lat_ext;
  tdeg_t t_q [3];
  logic  v_a1;
  diff_t d_a1;
  red_t  red_q [3];
  logic  v_a2;
  diff_t d_a2;

  cval_t cx [3][NSTG+1];
  cval_t cy [3][NSTG+1];
  cval_t cz [3][NSTG+1];
  logic  cn [3][NSTG+1];
  logic  cv [NSTG+1];
  diff_t cd [NSTG+1];

  logic signed [60:0] p_q [3];
  logic  pn_q [3];
  logic  v_p;
  diff_t d_p;

  logic signed [62:0] term [3];
  logic signed [62:0] sum;

  assign lat_ext = tdeg_t'(lat_deg);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a1 <= 1'b0;
      v_a2 <= 1'b0;
      cv[0] <= 1'b0;
      v_p <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a1 <= in_valid;
      v_a2 <= v_a1;
      cv[0] <= v_a2;
      v_p <= cv[NSTG];
      out_valid <= v_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_q[0] <= lat_ext;
      t_q[1] <= (lat_ext <<< 1) + lat_ext;
      t_q[2] <= (lat_ext <<< 2) + lat_ext;
      d_a1 <= in_diff;
      d_a2 <= d_a1;
      cd[0] <= d_a2;
      d_p <= cd[NSTG];
      out_diff <= d_p;
      mlon <= mlon_t'((sum + 63'sd536870912) >>> 30);
    end
  end

  generate
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic signed [49:0] zp;
      assign zp = 50'($signed(red_q[k].r)) * 50'(DEG2RAD_Q30);
      assign term[k] = pn_q[k] ? -63'(p_q[k]) : 63'(p_q[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          red_q[k] <= reduce_deg(t_q[k]);
          cx[k][0] <= GAIN_Q30;
          cy[k][0] <= '0;
          cz[k][0] <= cval_t'(zp >>> 16);
          cn[k][0] <= red_q[k].neg;
          p_q[k] <= 61'(cx[k][NSTG]) * 61'(k == 0 ? C1_COEF : (k == 1 ? C3_COEF : C5_COEF));
          pn_q[k] <= cn[k][NSTG];
        end
      end

      for (genvar g = 0; g < NSTG; g++) begin : g_stage
        localparam cval_t ATAN = cval_t'({2'b00, atan_q30(g)});
        always_ff @(posedge clk) begin
          if (en) begin
            if (cz[k][g] >= 0) begin
              cx[k][g+1] <= cx[k][g] - (cy[k][g] >>> g);
              cy[k][g+1] <= cy[k][g] + (cx[k][g] >>> g);
              cz[k][g+1] <= cz[k][g] - ATAN;
            end else begin
              cx[k][g+1] <= cx[k][g] + (cy[k][g] >>> g);
              cy[k][g+1] <= cy[k][g] - (cx[k][g] >>> g);
              cz[k][g+1] <= cz[k][g] + ATAN;
            end
            cn[k][g+1] <= cn[k][g];
          end
        end
      end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_side
      always_ff @(posedge clk) begin
        if (rst) begin
          cv[g+1] <= 1'b0;
        end else if (en) begin
          cv[g+1] <= cv[g];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cd[g+1] <= cd[g];
        end
      end
    end
  endgenerate

  // The cos 3L term enters with a minus sign.
  assign sum = term[0] - term[1] + term[2];

endmodule

// ----- rtl/wdb_vec_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdb_vec_cordic
// Unrolled vectoring CORDIC giving the scaled magnitude and atan2 angle of
// the latitude/longitude metre vector.
// ----------------------------------------------------------------------------
module wdb_vec_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  wdb_pkg::vval_t a,
  input  wdb_pkg::vval_t b,
  output logic           out_valid,
  output wdb_pkg::vval_t x,
  output wdb_pkg::vang_t z
);
  import wdb_pkg::*;

  vval_t a0;
  vval_t b0;
  vval_t vx [NSTG+1];
  vval_t vy [NSTG+1];
  vang_t vz [NSTG+1];
  logic  vv [NSTG+1];

  // A zero component is nudged to one LSB before the rotation.
  assign a0 = (a == '0) ? 64'sd1 : a;
  assign b0 = (b == '0) ? 64'sd1 : b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a0 < 0) begin
        vx[0] <= -a0;
        vy[0] <= -b0;
        vz[0] <= (b0 >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        vx[0] <= a0;
        vy[0] <= b0;
        vz[0] <= '0;
      end
    end
  end

  generate
    for (genvar g = 0; g < NSTG; g++) begin : g_stage
      localparam vang_t ATAN = vang_t'({4'b0000, atan_q30(g)});
      always_ff @(posedge clk) begin
        if (rst) begin
          vv[g+1] <= 1'b0;
        end else if (en) begin
          vv[g+1] <= vv[g];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (vy[g] >= 0) begin
            vx[g+1] <= vx[g] + (vy[g] >>> g);
            vy[g+1] <= vy[g] - (vx[g] >>> g);
            vz[g+1] <= vz[g] + ATAN;
          end else begin
            vx[g+1] <= vx[g] - (vy[g] >>> g);
            vy[g+1] <= vy[g] + (vx[g] >>> g);
            vz[g+1] <= vz[g] - ATAN;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vv[NSTG];
  assign x = vx[NSTG];
  assign z = vz[NSTG];

endmodule

// ----- rtl/wdb_dist_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdb_dist_div
// Removes the CORDIC gain from the magnitude and divides it by 1e8 through a
// reciprocal multiplication and a small remainder correction, saturating at
// all ones. Six register stages.
// ----------------------------------------------------------------------------
module wdb_dist_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  wdb_pkg::vval_t x,
  input  wdb_pkg::bear_t in_bear,
  output logic           out_valid,
  output logic [31:0]    dist_q8,
  output wdb_pkg::bear_t out_bear
);
  import wdb_pkg::*;

  logic [63:0] ux;
  logic [63:0] ph;
  logic [59:0] pl;
  logic        v_m;
  bear_t       b_m;
  logic [63:0] mag;

  logic [58:0] mg0;
  logic [58:0] mg1;
  logic [58:0] mg2;
  logic [63:0] prod;
  logic [31:0] q1;
  logic [31:0] q2;
  logic [31:0] q3;
  logic [58:0] qm2;
  logic [28:0] r3;
  logic [1:0]  corr;
  logic [31:0] quo;

  logic        sat [5];
  logic        dv  [5];
  bear_t       db  [5];

  assign ux = x[63] ? '0 : 64'(x);
  assign mag = ph + 64'(pl[59:30]);

  // Below the saturation limit the magnitude fits in 59 bits, so the top
  // 32 bits give a quotient estimate that is short by at most three.
  assign prod = 64'(mg0[58:27]) * 64'(DIST_RECIP);

  always_comb begin
    priority if (r3 >= DIST_DIV3) corr = 2'd3;
    else if (r3 >= DIST_DIV2) corr = 2'd2;
    else if (r3 >= 29'(DIST_DIV)) corr = 2'd1;
    else corr = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
      dv[0] <= 1'b0;
      dv[1] <= 1'b0;
      dv[2] <= 1'b0;
      dv[3] <= 1'b0;
      dv[4] <= 1'b0;
    end else if (en) begin
      v_m <= in_valid;
      dv[0] <= v_m;
      dv[1] <= dv[0];
      dv[2] <= dv[1];
      dv[3] <= dv[2];
      dv[4] <= dv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph <= 64'(ux[63:30]) * 64'(GAIN_U);
      pl <= 60'(ux[29:0]) * 60'(GAIN_U);
      b_m <= in_bear;

      sat[0] <= (mag >= DIST_LIM);
      mg0 <= mag[58:0];
      db[0] <= b_m;

      q1 <= prod[63:32];
      mg1 <= mg0;
      sat[1] <= sat[0];
      db[1] <= db[0];

      qm2 <= 59'(q1) * 59'(DIST_DIV);
      q2 <= q1;
      mg2 <= mg1;
      sat[2] <= sat[1];
      db[2] <= db[1];

      r3 <= 29'(mg2 - qm2);
      q3 <= q2;
      sat[3] <= sat[2];
      db[3] <= db[2];

      quo <= q3 + 32'(corr);
      sat[4] <= sat[3];
      db[4] <= db[3];
    end
  end

  assign out_valid = dv[4];
  assign dist_q8 = sat[4] ? '1 : quo;
  assign out_bear = db[4];

endmodule

// ----- rtl/waypoint_distance_bearing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_distance_bearing
// Planar distance and bearing from a position to a waypoint.
// ----------------------------------------------------------------------------
// Stages in order: entry register, cosine unit, metre product register,
// vectoring CORDIC, the six-stage divider and the output register.
// Throughput is one transaction per cycle; the whole pipeline holds while a
// result waits at the output register.
// Reset clears the valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module waypoint_distance_bearing (
  input logic       clk,
  input logic       rst,
  wdb_in_if.sink    query,
  wdb_out_if.source result
);
  import wdb_pkg::*;

  logic  adv;
  logic  out_valid;
  logic [31:0] out_dist;
  bear_t out_bear;

  logic  s0_valid;
  diff_t s0_diff;
  deg_t  s0_lat;

  logic  c_valid;
  mlon_t c_mlon;
  diff_t c_diff;

  logic  m_valid;
  vval_t m_a;
  vval_t m_b;

  logic  v_valid;
  vval_t v_x;
  vang_t v_z;
  vang_t ang;
  bear_t bq;

  logic  d_valid;
  logic [31:0] d_dist;
  bear_t d_bear;

  // Every stage moves only when the output register is free or being emptied.
  assign adv = !out_valid || result.ready;
  assign query.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      m_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= query.valid;
      m_valid <= c_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_diff.dlat <= dlat_t'(query.wp_lat_fixed) - dlat_t'(query.pos_lat_fixed);
      s0_diff.dlon <= dlon_t'(query.wp_lon_fixed) - dlon_t'(query.pos_lon_fixed);
      s0_lat <= query.pos_lat_deg;
      m_a <= 64'($signed(c_diff.dlat)) * 64'(MLAT_Q8);
      m_b <= 64'($signed(c_diff.dlon)) * 64'(c_mlon);
      out_dist <= d_dist;
      out_bear <= d_bear;
    end
  end

  wdb_cos_unit u_cos (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s0_valid),
    .lat_deg   (s0_lat),
    .in_diff   (s0_diff),
    .out_valid (c_valid),
    .mlon      (c_mlon),
    .out_diff  (c_diff)
  );

  wdb_vec_cordic u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (m_valid),
    .a         (m_a),
    .b         (m_b),
    .out_valid (v_valid),
    .x         (v_x),
    .z         (v_z)
  );

  // Negative angles are pushed down by a further quarter turn before rounding.
  assign ang = (v_z < 0) ? v_z - HALF_PI_Q30 : v_z;
  assign bq = bear_t'((ang + 36'sd65536) >>> 17);

  wdb_dist_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v_valid),
    .x         (v_x),
    .in_bear   (bq),
    .out_valid (d_valid),
    .dist_q8   (d_dist),
    .out_bear  (d_bear)
  );

  assign result.valid = out_valid;
  assign result.distance_q8 = out_dist;
  assign result.bearing_q13 = out_bear;

  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !query.ready)
    else $error("query accepted while result stalled");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    (query.valid && query.ready) |=> s0_valid)
    else $error("accepted transaction lost at pipeline entry");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && d_valid) |=> d_valid)
    else $error("pipeline moved during a stall");

endmodule

// ----- dv/waypoint_distance_bearing_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_distance_bearing_checker
// Watches the query and result channels of the distance and bearing block.
// It predicts each result from the accepted query and compares the distance
// and bearing fields in order. It reports the failure count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module waypoint_distance_bearing_checker (
  input  logic clk,
  input  logic rst,
  wdb_in_if    query,
  wdb_out_if   result,
  output int   errors,
  output int   pending
);

  localparam longint GAIN = 652032874;
  localparam longint PI_ANG = 64'sd3373259426;
  localparam longint HALF_PI_ANG = 1686629713;
  localparam longint RAD_PER_DEG = 18740330;
  localparam longint LAT_SCALE = 28450022;
  localparam longint COS1_W = 28521697;
  localparam longint COS3_W = 23936;
  localparam longint COS5_W = 31;
  localparam longint DEG_ONE = 65536;
  localparam int NUM_STAGES = wdb_pkg::NSTG;

  localparam longint ARCTAN [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  typedef struct {
    logic [31:0]        distance;
    logic signed [16:0] bearing;
  } fix_t;

  fix_t expected_fixes[$];

  // Cosine of an angle in Q.16 degrees, returned in Q.30.
  function automatic longint cosine_q30(input longint ang_deg);
    longint full_turn, half_turn, quarter_turn, r, x, y, z, nx;
    bit flip;
    full_turn = 360 * DEG_ONE;
    half_turn = 180 * DEG_ONE;
    quarter_turn = 90 * DEG_ONE;
    flip = 1'b0;
    r = ang_deg % full_turn;
    if (r < 0) r = r + full_turn;
    if (r >= half_turn) r = r - full_turn;
    if (r > quarter_turn) begin
      r = r - half_turn;
      flip = 1'b1;
    end else if (r < -quarter_turn) begin
      r = r + half_turn;
      flip = 1'b1;
    end
    z = (r * RAD_PER_DEG) >>> 16;
    x = GAIN;
    y = 0;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN[i];
      end
      x = nx;
    end
    return flip ? -x : x;
  endfunction

  function automatic fix_t predict_fix(input longint plat, input longint plon,
                                       input longint wlat, input longint wlon,
                                       input longint lat_deg);
    longint series, lon_scale, x, y, z, nx, ang;
    longint unsigned ux, mag, dist_q;
    fix_t f;
    series = COS1_W * cosine_q30(lat_deg) - COS3_W * cosine_q30(3 * lat_deg)
           + COS5_W * cosine_q30(5 * lat_deg);
    lon_scale = (series + (64'sd1 <<< 29)) >>> 30;
    x = (wlat - plat) * LAT_SCALE;
    y = (wlon - plon) * lon_scale;
    // A zero component is nudged to one LSB so the angle stays defined.
    if (x == 0) x = 1;
    if (y == 0) y = 1;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_ANG : -PI_ANG;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN[i];
      end
      x = nx;
    end
    ux = (x > 0) ? x : 0;
    mag = (ux >> 30) * GAIN + (((ux & 64'h3FFFFFFF) * GAIN) >> 30);
    dist_q = mag / 64'd100000000;
    if (dist_q > 64'hFFFFFFFF) dist_q = 64'hFFFFFFFF;
    ang = z;
    if (ang < 0) ang = ang - HALF_PI_ANG;
    f.distance = dist_q[31:0];
    f.bearing = 17'((ang + (64'sd1 <<< 16)) >>> 17);
    return f;
  endfunction

  assign pending = expected_fixes.size();

  always @(posedge clk) begin
    fix_t want;
    longint plat, plon, wlat, wlon, lat_deg;
    if (rst) begin
      errors <= 0;
    end else begin
      if (query.valid && query.ready) begin
        plat = query.pos_lat_fixed;
        plon = query.pos_lon_fixed;
        wlat = query.wp_lat_fixed;
        wlon = query.wp_lon_fixed;
        lat_deg = query.pos_lat_deg;
        expected_fixes.push_back(predict_fix(plat, plon, wlat, wlon, lat_deg));
      end
      if (result.valid && result.ready) begin
        if (expected_fixes.size() == 0) begin
          $display("%0t: result transaction with nothing expected: distance %0d bearing %0d",
                   $time, result.distance_q8, result.bearing_q13);
          errors <= errors + 1;
        end else begin
          want = expected_fixes.pop_front();
          if (want.distance !== result.distance_q8 || want.bearing !== result.bearing_q13) begin
            $display("%0t: mismatch: expected distance %0d bearing %0d, got distance %0d bearing %0d",
                     $time, want.distance, want.bearing, result.distance_q8,
                     result.bearing_q13);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/waypoint_distance_bearing_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_distance_bearing_tb
// Drives directed and random waypoint queries into the distance and bearing
// block under bursty input and a stalling receiver. The checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module waypoint_distance_bearing_tb;

  localparam int RANDOM_QUERIES = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam longint LAT_MAX = 900000000;
  localparam longint LON_MAX = 1800000000;
  localparam longint DEG_MAX = 5898240;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  int   burst_left;
  int   stall_mode;

  wdb_in_if  query ();
  wdb_out_if result ();

  waypoint_distance_bearing u_top (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .result (result)
  );

  waypoint_distance_bearing_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .query   (query),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver alternates between always ready, random stalls and long
  // stall stretches.
  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0: result.ready <= 1'b1;
      1: result.ready <= ($urandom_range(1) == 1);
      default: result.ready <= ((cycles % 24) >= 16);
    endcase
  end

  task automatic send_query(input longint plat, input longint plon, input longint wlat,
                            input longint wlon, input longint lat_deg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        query.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    query.valid <= 1'b1;
    query.pos_lat_fixed <= 31'(plat);
    query.pos_lon_fixed <= 32'(plon);
    query.wp_lat_fixed <= 31'(wlat);
    query.wp_lon_fixed <= 32'(wlon);
    query.pos_lat_deg <= 24'(lat_deg);
    @(posedge clk);
    while (!query.ready) @(posedge clk);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX;
  endfunction

  initial begin
    longint plat, plon, wlat, wlon, lat_deg;
    int kind;
    rst = 1'b1;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    query.valid = 1'b0;
    query.pos_lat_fixed = '0;
    query.pos_lon_fixed = '0;
    query.wp_lat_fixed = '0;
    query.wp_lon_fixed = '0;
    query.pos_lat_deg = '0;
    result.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Coincident points, zero components, the four quadrants, range extremes.
    send_query(0, 0, 0, 0, 0);
    send_query(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, DEG_MAX);
    send_query(0, 0, 1000, 0, 0);
    send_query(0, 0, -1000, 0, 0);
    send_query(0, 0, 0, 1000, 0);
    send_query(0, 0, 0, -1000, 0);
    send_query(0, 0, 5000, 3000, 3000000);
    send_query(0, 0, -5000, 3000, -3000000);
    send_query(0, 0, -5000, -3000, 1000000);
    send_query(0, 0, 5000, -3000, -1000000);
    send_query(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, -DEG_MAX);
    send_query(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, DEG_MAX);
    send_query(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 0);
    send_query(LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX, DEG_MAX / 2);
    // Latitudes in degrees beyond the pole, where the longitude scale can flip.
    send_query(0, 0, 2000, 7000, 24'sh7FFFFF);
    send_query(0, 0, 2000, 7000, -24'sh800000);
    send_query(0, 0, -2000, 7000, 8000000);
    // Full-width field extremes.
    send_query(-(64'sd1 <<< 30), -(64'sd1 <<< 31), (64'sd1 <<< 30) - 1, (64'sd1 <<< 31) - 1,
               24'sh7FFFFF);
    send_query((64'sd1 <<< 30) - 1, (64'sd1 <<< 31) - 1, -(64'sd1 <<< 30), -(64'sd1 <<< 31),
               -24'sh800000);
    send_query(0, 12345, 0, 12345, 0);
    send_query(777, 0, 777, 500, 0);

    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      kind = $urandom_range(9);
      plat = rand_lat();
      plon = rand_lon();
      lat_deg = (plat * 65536) / 10000000;
      if (kind < 5) begin
        // Nearby waypoint, the usual navigation case.
        wlat = plat + longint'($urandom_range(2000000)) - 1000000;
        wlon = plon + longint'($urandom_range(2000000)) - 1000000;
      end else if (kind < 7) begin
        wlat = rand_lat();
        wlon = rand_lon();
        lat_deg = longint'($urandom_range(32'(2 * DEG_MAX))) - DEG_MAX;
      end else if (kind == 7) begin
        // One difference zero.
        wlat = ($urandom_range(1) == 1) ? plat : plat + longint'($urandom_range(2000)) - 1000;
        wlon = (wlat == plat) ? plon + longint'($urandom_range(2000)) - 1000 : plon;
      end else begin
        plat = longint'(signed'(31'($urandom())));
        plon = longint'(signed'($urandom()));
        wlat = longint'(signed'(31'($urandom())));
        wlon = longint'(signed'($urandom()));
        lat_deg = longint'(signed'(24'($urandom())));
      end
      send_query(plat, plon, wlat, wlon, lat_deg);
    end
    query.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- waypoint_distance_bearing.f -----
rtl/wdb_pkg.sv
rtl/wdb_if.sv
rtl/wdb_cos_unit.sv
rtl/wdb_vec_cordic.sv
rtl/wdb_dist_div.sv
rtl/waypoint_distance_bearing.sv
dv/waypoint_distance_bearing_checker.sv
dv/waypoint_distance_bearing_tb.sv
